// ----- rtl/sorted_id_set_registry_unit_assert.svh -----
// Assertion macros shared by the sorted identifier set RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef SORTED_ID_SET_REGISTRY_UNIT_ASSERT_SVH
`define SORTED_ID_SET_REGISTRY_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled during reset
`define SIDR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sidr assertion failed");
// Next-cycle implication, disabled during reset
`define SIDR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sidr assertion failed");
`else
`define SIDR_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SIDR_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- rtl/sidr_pkg.sv -----
// Package for the sorted identifier set: defaults, request codes, result layout,
// controller state type and tree depth helper. No dependencies.
`default_nettype none

package sidr_pkg;

  localparam int SIDR_CAPACITY    = 1024;
  localparam int SIDR_IDENT_WIDTH = 64;
  localparam int SIDR_RADIX       = 8;   // fan-in of each OR tree node

  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 16;
  localparam int ENTRIES_W  = 11;

  // Request kinds carried on tuser
  localparam logic KIND_QUERY  = 1'b0;
  localparam logic KIND_INSERT = 1'b1;

  // Result word, lowest bit first: found, stored, full_refused, entries_now, pad
  typedef struct packed {
    logic [1:0]           pad;
    logic [ENTRIES_W-1:0] entries_now;
    logic                 full_refused;
    logic                 stored;
    logic                 found;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_WAIT = 3'b100
  } state_t;

  // Number of registered levels needed to reduce n leaves to one bit
  function automatic int tree_levels(input int n);
    int w;
    int l;
    w = n;
    l = 0;
    for (int i = 0; i < 32; i++) begin
      if (w > 1) begin
        w = (w + SIDR_RADIX - 1) / SIDR_RADIX;
        l++;
      end
    end
    return (l < 1) ? 1 : l;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/sorted_id_set_registry_unit.sv -----
// Each result waits on the registered OR tree that gathers the per-cell match flags.
// One request is handled at a time: a new request is taken once the previous result
// sits in the output register, and a stalled result channel holds the controller in
// the wait state, so no new request is taken until the result can be loaded.
// Reset (rst_n low, synchronous) empties the set and drops any pending result.
`default_nettype none
`include "sorted_id_set_registry_unit_assert.svh"

module sorted_id_set_registry_unit
  import sidr_pkg::*;
#(
  parameter int CAPACITY    = SIDR_CAPACITY,
  parameter int IDENT_WIDTH = SIDR_IDENT_WIDTH
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // [63:0] ident
  input  wire logic                  in_tuser,   // [0] kind
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata   // [0] found, [1] stored,
                                                 // [2] full_refused,
                                                 // [13:3] entries_now, [15:14] 0
);

  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int LEVELS = tree_levels(CAPACITY);
  localparam int WAIT_W = $clog2(LEVELS + 1);

  state_t state_r, state_nxt;

  logic                   kind_r;
  logic [IDENT_WIDTH-1:0] key_r;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic [WAIT_W-1:0]      wait_r, wait_nxt;
  logic                   stored_r;
  logic                   refused_r;
  logic                   out_tvalid_r, out_tvalid_nxt;
  res_t                   out_res_r;

  logic                   accept;
  logic                   full;
  logic                   ins_en;
  logic                   qry_exec;
  logic                   out_free;
  logic                   load_out;
  logic                   any_match;

  logic [CAPACITY-1:0]    gt;
  logic [IDENT_WIDTH-1:0] val [CAPACITY];
  logic [CAPACITY-1:0]    match;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign full      = (count_r == CNT_W'(CAPACITY));
  assign ins_en    = (state_r == ST_EXEC) && (kind_r == KIND_INSERT) && !full;
  assign qry_exec  = (state_r == ST_EXEC) && (kind_r == KIND_QUERY);
  assign out_free  = !out_tvalid_r || out_tready;
  assign load_out  = (state_r == ST_WAIT) && (wait_r == '0) && out_free;

  // Chain of cells, each fed by its lower neighbor
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                   prev_gt;
    logic [IDENT_WIDTH-1:0] prev_val;

    if (i == 0) begin : g_head
      assign prev_gt  = 1'b0;
      assign prev_val = key_r;
    end else begin : g_link
      assign prev_gt  = gt[i-1];
      assign prev_val = val[i-1];
    end

    sidr_cell #(
      .IDENT_W (IDENT_WIDTH),
      .CNT_W   (CNT_W),
      .IDX     (i)
    ) u_cell (
      .clk      (clk),
      .key      (key_r),
      .count    (count_r),
      .ins_en   (ins_en),
      .prev_gt  (prev_gt),
      .prev_val (prev_val),
      .gt       (gt[i]),
      .val      (val[i]),
      .match_r  (match[i])
    );
  end

  // Gather match flags
  sidr_or_tree #(
    .N (CAPACITY)
  ) u_tree (
    .clk    (clk),
    .leaves (match),
    .any    (any_match)
  );

  // Sequence one request: execute, wait for the tree, hand off the result
  always_comb begin
    state_nxt = state_r;
    wait_nxt  = wait_r;
    count_nxt = count_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt = ST_WAIT;
        wait_nxt  = WAIT_W'(LEVELS);
        if (ins_en) begin
          count_nxt = count_r + 1'b1;
        end
      end
      ST_WAIT: begin
        if (wait_r != '0) begin
          wait_nxt = wait_r - 1'b1;
        end else if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_tvalid_nxt = load_out || (out_tvalid_r && !out_tready);

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      wait_r       <= '0;
      count_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      wait_r       <= wait_nxt;
      count_r      <= count_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // Capture the request
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r <= in_tuser;
      key_r  <= in_tdata[IDENT_WIDTH-1:0];
    end
  end

  // Record the insert outcome
  always_ff @(posedge clk) begin
    if (state_r == ST_EXEC) begin
      stored_r  <= ins_en;
      refused_r <= (kind_r == KIND_INSERT) && full;
    end
  end

  // Load the output register
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_res_r.pad          <= '0;
      out_res_r.entries_now  <= ENTRIES_W'(count_r);
      out_res_r.full_refused <= refused_r;
      out_res_r.stored       <= stored_r;
      out_res_r.found        <= (kind_r == KIND_QUERY) && any_match;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_res_r;

  `SIDR_ASSERT_IMP(a_count_max, clk, rst_n, 1'b1, count_r <= CNT_W'(CAPACITY))
  `SIDR_ASSERT_NXT(a_ins_grow, clk, rst_n, ins_en, count_r == $past(count_r) + 1'b1)
  `SIDR_ASSERT_NXT(a_qry_hold, clk, rst_n, qry_exec, count_r == $past(count_r))
  `SIDR_ASSERT_IMP(a_res_excl, clk, rst_n, out_tvalid_r, !(out_res_r.stored && out_res_r.full_refused))
  `SIDR_ASSERT_IMP(a_load_wait, clk, rst_n, load_out, state_r == ST_WAIT)

endmodule

`default_nettype wire

// ----- rtl/sidr_cell.sv -----
// One storage cell of the sorted chain: holds one identifier, compares it with
// the broadcast key and takes its lower neighbor's entry on insert. Uses sidr_pkg.
`default_nettype none

module sidr_cell
  import sidr_pkg::*;
#(
  parameter int IDENT_W = SIDR_IDENT_WIDTH,
  parameter int CNT_W   = 11,
  parameter int IDX     = 0
) (
  input  wire logic               clk,
  input  wire logic [IDENT_W-1:0] key,
  input  wire logic [CNT_W-1:0]   count,
  input  wire logic               ins_en,
  input  wire logic               prev_gt,
  input  wire logic [IDENT_W-1:0] prev_val,
  output logic                    gt,
  output logic [IDENT_W-1:0]      val,
  output logic                    match_r
);

  logic [IDENT_W-1:0] val_r;
  logic               in_range;
  logic               wr_en;

  // Entry is live only below the fill count
  assign in_range = count > CNT_W'(IDX);
  assign gt       = in_range && (val_r > key);
  assign val      = val_r;

  // Write when this entry moves up, or when this is the first free slot
  assign wr_en = ins_en && (gt || (count == CNT_W'(IDX)));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      val_r <= prev_gt ? prev_val : key;
    end
  end

  // Register the equality flag for the OR tree
  always_ff @(posedge clk) begin
    match_r <= in_range && (val_r == key);
  end

endmodule

`default_nettype wire

// ----- rtl/sidr_or_tree.sv -----
// Registered OR reduction tree over the cell match flags, SIDR_RADIX inputs
// per node, one register level per stage. Uses sidr_pkg.
`default_nettype none

module sidr_or_tree
  import sidr_pkg::*;
#(
  parameter int N = SIDR_CAPACITY
) (
  input  wire logic         clk,
  input  wire logic [N-1:0] leaves,
  output logic              any
);

  localparam int LEVELS = tree_levels(N);

  logic [N-1:0] lvl_nxt [LEVELS];
  logic [N-1:0] lvl_r   [LEVELS];

  for (genvar l = 0; l < LEVELS; l++) begin : g_lvl
    logic [N-1:0] src;

    if (l == 0) begin : g_first
      assign src = leaves;
    end else begin : g_rest
      assign src = lvl_r[l-1];
    end

    // Reduce each group of RADIX bits of the level below
    always_comb begin
      lvl_nxt[l] = '0;
      for (int j = 0; j < N; j++) begin
        for (int k = 0; k < SIDR_RADIX; k++) begin
          if (j * SIDR_RADIX + k < N) begin
            lvl_nxt[l][j] = lvl_nxt[l][j] | src[j * SIDR_RADIX + k];
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      lvl_r[l] <= lvl_nxt[l];
    end
  end

  assign any = lvl_r[LEVELS-1][0];

endmodule

`default_nettype wire

// ----- tb/sidr_result_checker.sv -----
// Result checker for the sorted identifier set: watches both stream channels,
// keeps a shadow copy of the set and compares every result field by field.
// Depends on sidr_pkg for the request codes and the result layout.
`default_nettype none

module sidr_result_checker
  import sidr_pkg::*;
#(
  parameter int CAPACITY    = SIDR_CAPACITY,
  parameter int IDENT_WIDTH = SIDR_IDENT_WIDTH
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  input  wire logic                  in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // [63:0] ident
  input  wire logic                  in_tuser,   // [0] kind
  input  wire logic                  out_tvalid,
  input  wire logic                  out_tready,
  input  wire logic [OUT_DATA_W-1:0] out_tdata,  // [0] found, [1] stored,
                                                 // [2] full_refused,
                                                 // [13:3] entries_now, [15:14] 0
  output int                         fail_count,
  output int                         pending_results
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] ID_MASK =
    (IDENT_WIDTH >= 64) ? {64{1'b1}} : ((64'd1 << IDENT_WIDTH) - 64'd1);

  // Shadow copy of the set, ascending, valid below shadow_count
  logic [63:0] shadow_ids [CAPACITY];
  int          shadow_count;
  res_t        awaited_results [$];

  initial begin
    fail_count      = 0;
    pending_results = 0;
    shadow_count    = 0;
  end

  // Binary search over the occupied part of the shadow set
  function automatic logic id_present(input logic [63:0] key);
    int lo;
    int hi;
    int mid;
    lo = 0;
    hi = shadow_count;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (shadow_ids[mid] == key) return 1'b1;
      if (shadow_ids[mid] < key) lo = mid + 1;
      else hi = mid;
    end
    return 1'b0;
  endfunction

  // Apply one request to the shadow set and return the result it must produce
  function automatic res_t apply_request(input logic kind,
                                         input logic [IN_DATA_W-1:0] raw);
    res_t        r;
    logic [63:0] key;
    int          pos;
    r   = '0;
    key = raw & ID_MASK;
    if (kind == KIND_QUERY) begin
      r.found = id_present(key);
    end else if (shadow_count >= CAPACITY) begin
      r.full_refused = 1'b1;
    end else begin
      // shift strictly larger entries up, so a duplicate lands after its equals
      pos = shadow_count;
      while (pos > 0 && shadow_ids[pos-1] > key) begin
        shadow_ids[pos] = shadow_ids[pos-1];
        pos--;
      end
      shadow_ids[pos] = key;
      shadow_count++;
      r.stored = 1'b1;
    end
    r.entries_now = ENTRIES_W'(shadow_count);
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("result field %s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Retire results before taking the request of the same edge
  always @(posedge clk) begin : watch_channels
    res_t got;
    res_t want;
    if (!rst_n) begin
      shadow_count = 0;
      awaited_results.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (awaited_results.size() == 0) begin
          $error("result %h arrived with no request outstanding", got);
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          check_field("found", 32'(want.found), 32'(got.found));
          check_field("stored", 32'(want.stored), 32'(got.stored));
          check_field("full_refused", 32'(want.full_refused), 32'(got.full_refused));
          check_field("entries_now", 32'(want.entries_now), 32'(got.entries_now));
          check_field("pad", 32'(want.pad), 32'(got.pad));
        end
      end
      if (in_tvalid && in_tready)
        awaited_results.push_back(apply_request(in_tuser, in_tdata));
    end
    pending_results = awaited_results.size();
  end

endmodule

`default_nettype wire

// ----- tb/sorted_id_set_registry_unit_tb.sv -----
// Testbench top for the sorted identifier set: clock, reset, request stimulus,
// result back-pressure, watchdog and verdict.
// Depends on sidr_pkg, sorted_id_set_registry_unit and sidr_result_checker.
`default_nettype none

module sorted_id_set_registry_unit_tb;
  import sidr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 2000;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;   // [63:0] ident
  logic                  in_tuser   = 1'b0; // [0] kind
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;         // [0] found, [1] stored,
                                            // [2] full_refused,
                                            // [13:3] entries_now, [15:14] 0
  int fail_count;
  int pending_results;

  // Stimulus-side bookkeeping: identifiers the set should now hold
  logic [63:0] inserted_pool [$];
  int          idle_pct     = 0;
  int          stall_pct    = 0;
  int          inserts_sent = 0;
  int          queries_sent = 0;
  int          refused_sent = 0;
  int          quiet_cycles = 0;

  always #10 clk = ~clk;

  sorted_id_set_registry_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  sidr_result_checker result_monitor (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  // Stall the result channel at the current rate
  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Abort when neither channel moves for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one request at a falling edge, hold it until accepted
  task automatic send_request(input logic kind, input logic [63:0] ident);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= ident;
    in_tuser  <= kind;
    do @(posedge clk); while (!in_tready);
    if (kind == KIND_INSERT) begin
      if (inserted_pool.size() < SIDR_CAPACITY) inserted_pool.push_back(ident);
      else refused_sent++;
      inserts_sent++;
    end else begin
      queries_sent++;
    end
    @(negedge clk);
  endtask

  // Hold off requests until every outstanding result has been taken
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending_results != 0);
  endtask

  // Mix of full-range, small (duplicate-prone), extreme, repeated and near-hit identifiers
  function automatic logic [63:0] pick_ident();
    int          r;
    logic [63:0] base;
    r = $urandom_range(0, 99);
    if (r < 35) return {$urandom, $urandom};
    if (r < 55) return 64'($urandom_range(0, 63));
    if (r < 65) begin
      case ($urandom_range(0, 4))
        0: return 64'd0;
        1: return {64{1'b1}};
        2: return 64'd1;
        3: return {1'b1, 63'd0};
        default: return {{63{1'b1}}, 1'b0};
      endcase
    end
    if (inserted_pool.size() == 0) return {$urandom, $urandom};
    base = inserted_pool[$urandom_range(0, inserted_pool.size() - 1)];
    if (r < 85) return base;
    return $urandom_range(0, 1) ? base + 64'd1 : base - 64'd1;
  endfunction

  initial begin
    int   n;
    int   phase;
    logic kind;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty-set queries, single entry, extremes, duplicates, misses
    send_request(KIND_QUERY,  64'd0);
    send_request(KIND_QUERY,  {64{1'b1}});
    send_request(KIND_INSERT, 64'd5);
    send_request(KIND_QUERY,  64'd5);
    send_request(KIND_QUERY,  64'd4);
    send_request(KIND_QUERY,  64'd6);
    send_request(KIND_INSERT, 64'd0);
    send_request(KIND_INSERT, {64{1'b1}});
    send_request(KIND_INSERT, 64'h8000_0000_0000_0000);
    send_request(KIND_INSERT, 64'h7FFF_FFFF_FFFF_FFFF);
    send_request(KIND_INSERT, 64'd0);
    send_request(KIND_INSERT, {64{1'b1}});
    send_request(KIND_INSERT, 64'hAAAA_AAAA_AAAA_AAAA);
    send_request(KIND_INSERT, 64'h5555_5555_5555_5555);
    send_request(KIND_QUERY,  64'd0);
    send_request(KIND_QUERY,  {64{1'b1}});
    send_request(KIND_QUERY,  64'h8000_0000_0000_0000);
    send_request(KIND_QUERY,  64'h7FFF_FFFF_FFFF_FFFF);
    send_request(KIND_QUERY,  64'hAAAA_AAAA_AAAA_AAAA);
    send_request(KIND_QUERY,  64'h5555_5555_5555_5555);
    send_request(KIND_QUERY,  64'd1);
    send_request(KIND_QUERY,  64'hFFFF_FFFF_FFFF_FFFE);

    // Random: insert-heavy mix of requests over the idle and stall phases
    n = 0;
    while (n < 728) begin
      if (n % 150 == 0) begin
        drain_results();
        phase = (n / 150) % 4;
        case (phase)
          0: begin idle_pct = 0;  stall_pct = 0;  end
          1: begin idle_pct = 48; stall_pct = 0;  end
          2: begin idle_pct = 0;  stall_pct = 48; end
          default: begin idle_pct = 32; stall_pct = 32; end
        endcase
      end
      if (inserted_pool.size() < SIDR_CAPACITY)
        kind = ($urandom_range(0, 99) < 80) ? KIND_INSERT : KIND_QUERY;
      else
        kind = $urandom_range(0, 1) ? KIND_INSERT : KIND_QUERY;
      send_request(kind, pick_ident());
      n++;
    end

    drain_results();
    repeat (20) @(posedge clk);

    $display("covered %0d queries and %0d inserts, leaving %0d entries in the set;",
             queries_sent, inserts_sent, inserted_pool.size());
    $display("%0d inserts met a full set, under mixed idle and stall rates",
             refused_sent);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
